FILE: design/tffd_pkg.sv
// Shared types, item codes and frame byte tables for the three-type frame deframer.
`timescale 1ns / 1ps
`default_nettype none

package tffd_pkg;

  localparam int PAYLOAD_MAX_DEFAULT = 13;

  localparam logic [3:0] SHORT_LEN = 4'd6;

  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_TYPE    = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;

  localparam logic [1:0] TYPE_NONE  = 2'd0;
  localparam logic [1:0] TYPE_ONE   = 2'd1;
  localparam logic [1:0] TYPE_TWO   = 2'd2;
  localparam logic [1:0] TYPE_THREE = 2'd3;

  localparam logic [7:0] HDR1_B0 = 8'hAB;
  localparam logic [7:0] HDR1_B1 = 8'hBA;
  localparam logic [7:0] HDR2_B0 = 8'hCD;
  localparam logic [7:0] HDR2_B1 = 8'hDC;
  localparam logic [7:0] HDR3_B0 = 8'hEF;
  localparam logic [7:0] HDR3_B1 = 8'hFE;
  localparam logic [7:0] TRL1_B0 = 8'h55;
  localparam logic [7:0] TRL1_B1 = 8'h56;
  localparam logic [7:0] TRL2_B0 = 8'h57;
  localparam logic [7:0] TRL2_B1 = 8'h58;
  localparam logic [7:0] TRL3_B0 = 8'h53;
  localparam logic [7:0] TRL3_B1 = 8'h54;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_TRAILER = 2'd2
  } phase_t;

  typedef struct packed {
    logic        is_frame;
    logic [1:0]  ftype;
    logic [15:0] retry;
  } cmd_t;

  // Returns the frame type whose header byte at the given position matches, or none.
  function automatic logic [1:0] header_type(input logic [7:0] b, input logic sel);
    logic [1:0] t;
    t = TYPE_NONE;
    if (!sel) begin
      if (b == HDR1_B0) t = TYPE_ONE;
      else if (b == HDR2_B0) t = TYPE_TWO;
      else if (b == HDR3_B0) t = TYPE_THREE;
    end else begin
      if (b == HDR1_B1) t = TYPE_ONE;
      else if (b == HDR2_B1) t = TYPE_TWO;
      else if (b == HDR3_B1) t = TYPE_THREE;
    end
    return t;
  endfunction

  // Expected trailer byte; an unknown type uses the first table row.
  function automatic logic [7:0] trailer_byte(input logic [1:0] ftype, input logic sel);
    logic [7:0] b;
    case (ftype)
      TYPE_TWO:   b = sel ? TRL2_B1 : TRL2_B0;
      TYPE_THREE: b = sel ? TRL3_B1 : TRL3_B0;
      default:    b = sel ? TRL1_B1 : TRL1_B0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: design/tffd_front.sv
// Front end: accepts received bytes, tracks frame sync and stores payload bytes.
`timescale 1ns / 1ps
`default_nettype none

module tffd_front #(
  parameter int PAYLOAD_MAX = tffd_pkg::PAYLOAD_MAX_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       rx_valid,
  output logic                            rx_stall,
  input  wire logic [7:0]                 rx_byte,
  input  wire logic                       q_full,
  output logic                            push,
  output tffd_pkg::cmd_t                  cmd,
  output logic [8*PAYLOAD_MAX-1:0]        payload
);

  localparam logic [3:0] LEN_LONG = 4'(PAYLOAD_MAX);

  tffd_pkg::phase_t phase, phase_next;
  logic [3:0]  position, position_next;
  logic [1:0]  frame_type, frame_type_next;
  logic [15:0] error_count, error_count_next;
  logic [7:0]  store [PAYLOAD_MAX];
  logic        frame_done;
  logic [3:0]  pos_inc;
  logic [3:0]  len;
  logic [1:0]  hit_type;

  assign rx_stall = q_full;
  assign push     = rx_valid && !q_full;
  assign len      = (frame_type == tffd_pkg::TYPE_TWO) ? LEN_LONG : tffd_pkg::SHORT_LEN;
  assign pos_inc  = position + 4'd1;
  assign hit_type = tffd_pkg::header_type(rx_byte, position[0]);

  always_comb begin
    phase_next       = phase;
    position_next    = position;
    frame_type_next  = frame_type;
    error_count_next = error_count;
    frame_done       = 1'b0;
    case (phase)
      tffd_pkg::PH_PAYLOAD: begin
        position_next = pos_inc;
        if (pos_inc >= len) begin
          phase_next    = tffd_pkg::PH_TRAILER;
          position_next = 4'd0;
        end
      end
      tffd_pkg::PH_TRAILER: begin
        if (rx_byte != tffd_pkg::trailer_byte(frame_type, position[0])) begin
          phase_next       = tffd_pkg::PH_HEADER;
          position_next    = 4'd0;
          frame_type_next  = tffd_pkg::TYPE_NONE;
          error_count_next = error_count + 16'd1;
        end else if (position == 4'd0) begin
          position_next = 4'd1;
        end else begin
          phase_next       = tffd_pkg::PH_HEADER;
          position_next    = 4'd0;
          error_count_next = 16'd0;
          frame_done       = 1'b1;
        end
      end
      default: begin
        phase_next = tffd_pkg::PH_HEADER;
        if (hit_type == tffd_pkg::TYPE_NONE) begin
          position_next    = 4'd0;
          error_count_next = error_count + 16'd1;
        end else if (!position[0]) begin
          position_next = 4'd1;
        end else begin
          frame_type_next = hit_type;
          phase_next      = tffd_pkg::PH_PAYLOAD;
          position_next   = 4'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= tffd_pkg::PH_HEADER;
      position    <= 4'd0;
      frame_type  <= tffd_pkg::TYPE_NONE;
      error_count <= 16'd0;
    end else if (push) begin
      phase       <= phase_next;
      position    <= position_next;
      frame_type  <= frame_type_next;
      error_count <= error_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && phase == tffd_pkg::PH_PAYLOAD) begin
      for (int i = 0; i < PAYLOAD_MAX; i++) begin
        if (position == 4'(i)) store[i] <= rx_byte;
      end
    end
  end

  always_comb begin
    cmd.is_frame = frame_done;
    cmd.ftype    = frame_type;
    cmd.retry    = error_count_next;
    for (int i = 0; i < PAYLOAD_MAX; i++) begin
      payload[8*i +: 8] = store[i];
    end
  end

endmodule

`default_nettype wire

FILE: design/tffd_queue.sv
// Two-entry queue that carries commands from the front end to the back end.
`timescale 1ns / 1ps
`default_nettype none

module tffd_queue #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  output logic                  not_empty,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign rd_data   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= wr_data;
  end

endmodule

`default_nettype wire

FILE: design/tffd_back.sv
// Back end: turns queued commands into status, type and payload result items.
`timescale 1ns / 1ps
`default_nettype none

module tffd_back #(
  parameter int PAYLOAD_MAX = tffd_pkg::PAYLOAD_MAX_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     q_valid,
  input  wire tffd_pkg::cmd_t           cmd,
  input  wire logic [8*PAYLOAD_MAX-1:0] payload,
  output logic                          pop,
  output logic                          res_valid,
  input  wire logic                     res_stall,
  output logic [1:0]                    item_kind,
  output logic [7:0]                    out_byte,
  output logic [15:0]                   retry_count,
  output logic                          last_of_run
);

  localparam logic [3:0] LEN_LONG = 4'(PAYLOAD_MAX);

  logic       busy;
  logic [3:0] remain;
  logic [7:0] shift [PAYLOAD_MAX];
  logic       advance;

  assign advance = !res_valid || !res_stall;
  assign pop     = advance && !busy && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      busy      <= 1'b0;
      remain    <= 4'd0;
    end else if (advance) begin
      if (busy) begin
        res_valid <= 1'b1;
        remain    <= remain - 4'd1;
        busy      <= (remain != 4'd1);
      end else if (q_valid) begin
        res_valid <= 1'b1;
        if (cmd.is_frame) begin
          busy   <= 1'b1;
          remain <= (cmd.ftype == tffd_pkg::TYPE_TWO) ? LEN_LONG : tffd_pkg::SHORT_LEN;
        end
      end else begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (busy) begin
        item_kind   <= tffd_pkg::KIND_PAYLOAD;
        out_byte    <= shift[0];
        last_of_run <= (remain == 4'd1);
        for (int i = 0; i < PAYLOAD_MAX - 1; i++) begin
          shift[i] <= shift[i+1];
        end
      end else if (q_valid) begin
        retry_count <= cmd.retry;
        if (cmd.is_frame) begin
          item_kind   <= tffd_pkg::KIND_TYPE;
          out_byte    <= {6'd0, cmd.ftype};
          last_of_run <= 1'b0;
          for (int i = 0; i < PAYLOAD_MAX; i++) begin
            shift[i] <= payload[8*i +: 8];
          end
        end else begin
          item_kind   <= tffd_pkg::KIND_STATUS;
          out_byte    <= 8'd0;
          last_of_run <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/three_type_frame_deframer_top.sv
// Top level of the three-type frame deframer: front end, command queue and back end.
//
//   Channel  Direction  Handshake           Payload
//   rx       in         rx_valid/rx_stall   rx_byte
//   res      out        res_valid/res_stall item_kind, out_byte, retry_count, last_of_run
//
// The front end takes one byte per cycle while the two-entry queue has room.
// The back end emits one result per cycle while res_stall is low: a status item for
// a byte that ends no frame, or a type item and then 6 or PAYLOAD_MAX payload items.
// Reset is synchronous and clears sync state, error count and the queue.
// A stall on the result side fills the queue and then stalls the byte input.
`timescale 1ns / 1ps
`default_nettype none

module three_type_frame_deframer_top #(
  parameter int PAYLOAD_MAX = tffd_pkg::PAYLOAD_MAX_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        rx_valid,
  output logic             rx_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [1:0]       item_kind,
  output logic [7:0]       out_byte,
  output logic [15:0]      retry_count,
  output logic             last_of_run
);

  localparam int QW = $bits(tffd_pkg::cmd_t) + 8 * PAYLOAD_MAX;

  logic                     push;
  logic                     q_full;
  logic                     q_valid;
  logic                     pop;
  tffd_pkg::cmd_t           front_cmd;
  tffd_pkg::cmd_t           back_cmd;
  logic [8*PAYLOAD_MAX-1:0] front_payload;
  logic [8*PAYLOAD_MAX-1:0] back_payload;
  logic [QW-1:0]            q_rd;

  tffd_front #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_front (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .push     (push),
    .cmd      (front_cmd),
    .payload  (front_payload)
  );

  tffd_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_data   ({front_cmd, front_payload}),
    .full      (q_full),
    .not_empty (q_valid),
    .pop       (pop),
    .rd_data   (q_rd)
  );

  assign back_cmd     = q_rd[QW-1 -: $bits(tffd_pkg::cmd_t)];
  assign back_payload = q_rd[8*PAYLOAD_MAX-1:0];

  tffd_back #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .cmd         (back_cmd),
    .payload     (back_payload),
    .pop         (pop),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .item_kind   (item_kind),
    .out_byte    (out_byte),
    .retry_count (retry_count),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

FILE: design/tffd_checker.sv
// Port-level assertions for the three-type frame deframer and their binding.
`timescale 1ns / 1ps
`default_nettype none

module tffd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        res_valid,
  input wire logic        res_stall,
  input wire logic [1:0]  item_kind,
  input wire logic [7:0]  out_byte,
  input wire logic [15:0] retry_count,
  input wire logic        last_of_run
);

  a_reset_clears_output: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("Result valid after reset.");

  a_stalled_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(out_byte) && $stable(item_kind))
    else $error("Stalled result transaction changed.");

  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid && item_kind == tffd_pkg::KIND_STATUS |-> out_byte == 8'd0 && last_of_run)
    else $error("Status transaction is malformed.");

  a_type_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid && item_kind == tffd_pkg::KIND_TYPE |->
      !last_of_run && retry_count == 16'd0 &&
      (out_byte == 8'd1 || out_byte == 8'd2 || out_byte == 8'd3))
    else $error("Frame type transaction is malformed.");

endmodule

bind three_type_frame_deframer_top tffd_checker u_tffd_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res_valid),
  .res_stall   (res_stall),
  .item_kind   (item_kind),
  .out_byte    (out_byte),
  .retry_count (retry_count),
  .last_of_run (last_of_run)
);

`default_nettype wire
